// ===== sv/tbac_pkg.sv =====
`timescale 1ns / 1ps

package tbac_pkg;

    // Mode codes
    localparam logic [1:0] MODE_SLOW   = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_FAST   = 2'd2;

    localparam int unsigned DELTA_W    = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned LED_W      = 8;
    localparam logic [6:0]  MOVE_LIMIT = 7'd127;
    localparam logic [7:0]  LED_ON     = 8'h80;

    // Stream packing
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_TUSER_W = 2;

    // Horner step selection
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,   // acc = c3*m + c2
        PH_MID   = 2'd1,   // acc = acc*m + c1
        PH_LAST  = 2'd2    // acc = acc*m
    } t_phase;

    typedef struct packed {
        logic   accept;
        logic   mul_en;
        t_phase phase;
        logic   axis_y;
        logic   save_x;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [LED_W-1:0] red;
        logic [LED_W-1:0] green;
        logic [LED_W-1:0] blue;
        logic [LED_W-1:0] white;
    } t_led;

    function automatic t_led mode_led(input logic [MODE_W-1:0] mode);
        t_led led;
        case (mode)
            MODE_SLOW:   led = '{red: 8'h00, green: LED_ON, blue: 8'h00, white: LED_ON};
            MODE_NORMAL: led = '{red: 8'h00, green: 8'h00, blue: LED_ON, white: LED_ON};
            default:     led = '{red: LED_ON, green: 8'h00, blue: 8'h00, white: LED_ON};
        endcase
        return led;
    endfunction

endpackage

// ===== sv/tbac_ctrl.sv =====
`timescale 1ns / 1ps

module tbac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output tbac_pkg::t_dp_cmd o_cmd
);
    import tbac_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_X1   = 8'b0000_0010,
        ST_X2   = 8'b0000_0100,
        ST_X3   = 8'b0000_1000,
        ST_Y1   = 8'b0001_0000,
        ST_Y2   = 8'b0010_0000,
        ST_Y3   = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{accept: 1'b0, mul_en: 1'b0, phase: PH_FIRST,
                    axis_y: 1'b0, save_x: 1'b0, out_load: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_X1;
                end
            end
            ST_X1: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_X2;
            end
            ST_X2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.phase  = PH_MID;
                n_state      = ST_X3;
            end
            ST_X3: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.phase  = PH_LAST;
                n_state      = ST_Y1;
            end
            ST_Y1: begin
                // acc still holds the x sum here
                o_cmd.mul_en = 1'b1;
                o_cmd.axis_y = 1'b1;
                o_cmd.save_x = 1'b1;
                n_state      = ST_Y2;
            end
            ST_Y2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.axis_y = 1'b1;
                o_cmd.phase  = PH_MID;
                n_state      = ST_Y3;
            end
            ST_Y3: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.axis_y = 1'b1;
                o_cmd.phase  = PH_LAST;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/tbac_dp.sv =====
`timescale 1ns / 1ps

module tbac_dp #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int MODE_COUNT     = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tbac_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [tbac_pkg::DELTA_W-1:0] i_delta_x,
    input  logic signed [tbac_pkg::DELTA_W-1:0] i_delta_y,
    input  logic                              i_button,
    output logic signed [tbac_pkg::DELTA_W-1:0] o_move_x,
    output logic signed [tbac_pkg::DELTA_W-1:0] o_move_y,
    output logic                              o_move_valid,
    output logic [tbac_pkg::MODE_W-1:0]       o_speed_mode,
    output logic                              o_mode_changed,
    output tbac_pkg::t_led                    o_led
);
    import tbac_pkg::*;

    localparam int F  = COEF_FRAC_BITS;
    // c < 2^F, m <= 2^7: full sum < 2^(F+22)
    localparam int AW = F + 22;

    localparam longint ONE = 64'd1 << F;
    localparam logic [F-1:0] C_030 = F'(((2 * 3 * ONE) + 10) / 20);
    localparam logic [F-1:0] C_040 = F'(((2 * 4 * ONE) + 10) / 20);
    localparam logic [F-1:0] C_050 = F'(((2 * 1 * ONE) + 2) / 4);
    localparam logic [F-1:0] C_025 = F'(((2 * 1 * ONE) + 4) / 8);

    logic                 r_button_before;
    logic [MODE_W-1:0]    r_mode;
    logic                 r_changed;
    logic [DELTA_W-1:0]   r_dx, r_dy;
    logic [AW-1:0]        r_acc, n_acc;
    logic [DELTA_W-1:0]   r_move_x_hold;

    logic [2:0]           mode_inc;
    logic [MODE_W-1:0]    mode_next;
    logic [F-1:0]         c3, c2, c1;
    logic [DELTA_W-1:0]   m;
    logic [AW-1:0]        mul_a, add_b;
    logic [AW-1:0]        prod;
    logic [6:0]           sat_mag;
    logic [DELTA_W-1:0]   signed_move;
    logic                 cur_neg;

    function automatic logic [DELTA_W-1:0] magnitude(input logic [DELTA_W-1:0] v);
        return v[DELTA_W-1] ? DELTA_W'(~v + 1'b1) : v;
    endfunction

    // Mode step on a rising switch edge
    always_comb begin
        mode_inc = {1'b0, r_mode} + 3'd1;
        if (mode_inc >= 3'(MODE_COUNT)) begin
            mode_next = MODE_SLOW;
        end else begin
            mode_next = mode_inc[MODE_W-1:0];
        end
    end

    always_comb begin
        case (r_mode)
            MODE_SLOW: begin
                c3 = C_030; c2 = C_040; c1 = C_030;
            end
            MODE_NORMAL: begin
                c3 = C_040; c2 = C_030; c1 = C_030;
            end
            default: begin
                c3 = C_050; c2 = C_025; c1 = C_025;
            end
        endcase
    end

    // Shared Horner multiply-add
    assign m = i_cmd.axis_y ? magnitude(r_dy) : magnitude(r_dx);

    always_comb begin
        case (i_cmd.phase)
            PH_FIRST: begin
                mul_a = AW'(c3);
                add_b = AW'(c2);
            end
            PH_MID: begin
                mul_a = r_acc;
                add_b = AW'(c1);
            end
            default: begin
                mul_a = r_acc;
                add_b = '0;
            end
        endcase
        prod  = AW'({{DELTA_W{1'b0}}, mul_a} * {{AW{1'b0}}, m});
        n_acc = prod + add_b;
    end

    // Truncate, saturate, apply sign of the axis held in acc
    assign cur_neg = i_cmd.save_x ? r_dx[DELTA_W-1] : r_dy[DELTA_W-1];

    always_comb begin
        if (r_acc[AW-1:F] > (AW-F)'(MOVE_LIMIT)) begin
            sat_mag = MOVE_LIMIT;
        end else begin
            sat_mag = r_acc[F+6:F];
        end
        signed_move = cur_neg ? DELTA_W'(~{1'b0, sat_mag} + 1'b1) : {1'b0, sat_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_before <= 1'b0;
            r_mode          <= MODE_SLOW;
        end else if (i_cmd.accept) begin
            r_button_before <= i_button;
            if (i_button && !r_button_before) begin
                r_mode <= mode_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dx      <= i_delta_x;
            r_dy      <= i_delta_y;
            r_changed <= i_button && !r_button_before;
        end
        if (i_cmd.mul_en) begin
            r_acc <= n_acc;
        end
        if (i_cmd.save_x) begin
            r_move_x_hold <= signed_move;
        end
        if (i_cmd.out_load) begin
            o_move_x       <= r_move_x_hold;
            o_move_y       <= signed_move;
            o_move_valid   <= (r_dx != '0) || (r_dy != '0);
            o_speed_mode   <= r_mode;
            o_mode_changed <= r_changed;
            o_led          <= mode_led(r_mode);
        end
    end

endmodule

// ===== sv/trackball_accel_curve_modes_top.sv =====
`timescale 1ns / 1ps
// Trackball acceleration with switch-selected speed modes.
// Input stream (s_axis): one item per trackball report. tdata carries the
// signed x and y deltas, tuser[0] the switch level. A rising switch edge
// steps the mode slow -> normal -> fast -> slow.
// Output stream (m_axis): one item per input item. tdata carries the
// accelerated x/y moves (cubic curve on magnitude, truncated, saturated at
// 127, sign restored), the mode and its LED color; tuser flags move_valid
// (either delta nonzero) and mode_changed.
// One shared multiplier runs three Horner steps per axis, x then y; a new
// item is not accepted until those steps are done and the result is loaded.
// The result sits in an output register; the next item is accepted as soon
// as the result has moved there, even if the receiver has not taken it yet.
// If the receiver stalls, the finished second item waits in the datapath
// until the output register frees up.
// Reset (synchronous, active low): mode slow, switch seen as released,
// no output pending.
module trackball_accel_curve_modes_top #(
    parameter int COEF_FRAC_BITS = 16,   // coefficient fraction bits, 8..24
    parameter int MODE_COUNT     = 3     // number of modes in the cycle, 1..4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // [7:0] delta_x, [15:8] delta_y
    input  logic [15:0] s_axis_tdata,
    // [0] button
    input  logic [0:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] move_x, [15:8] move_y, [17:16] speed_mode, [25:18] led_red,
    // [33:26] led_green, [41:34] led_blue, [49:42] led_white, [55:50] zero
    output logic [55:0] m_axis_tdata,
    // [0] move_valid, [1] mode_changed
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);
    import tbac_pkg::*;

    t_dp_cmd                   cmd;
    logic signed [DELTA_W-1:0] move_x, move_y;
    logic                      move_valid, mode_changed;
    logic [MODE_W-1:0]         speed_mode;
    t_led                      led;

    tbac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd)
    );

    tbac_dp #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .MODE_COUNT     (MODE_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_delta_x      (s_axis_tdata[7:0]),
        .i_delta_y      (s_axis_tdata[15:8]),
        .i_button       (s_axis_tuser[0]),
        .o_move_x       (move_x),
        .o_move_y       (move_y),
        .o_move_valid   (move_valid),
        .o_speed_mode   (speed_mode),
        .o_mode_changed (mode_changed),
        .o_led          (led)
    );

    assign m_axis_tdata = {6'd0, led.white, led.blue, led.green, led.red,
                           speed_mode, move_y, move_x};
    assign m_axis_tuser = {mode_changed, move_valid};

endmodule

// ===== dv/tb_trackball_accel_curve_modes_top.sv =====
`timescale 1ns / 1ps

module tb_trackball_accel_curve_modes_top;
    import tbac_pkg::*;

    localparam int COEF_FRAC_BITS = 16;
    localparam int MODE_COUNT     = 3;
    localparam int RANDOM_REPORTS = 1700;
    localparam int PHASE_LEN      = 600;     // reports per idling phase
    localparam int SETTLE_CYCLES  = 40;      // well above the output latency
    localparam int CYCLE_LIMIT    = 400000;

    // One trackball report queued for the driver
    typedef struct {
        logic [7:0] dx;
        logic [7:0] dy;
        logic       btn;
        logic       hold_off;   // wait until all moves are back before sending
    } t_report;

    // One expected move item
    typedef struct {
        logic [7:0] move_x;
        logic [7:0] move_y;
        logic       valid;
        logic [1:0] mode;
        logic       changed;
        t_led       led;
    } t_move;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [15:0] s_axis_tdata = '0;     // [7:0] delta_x, [15:8] delta_y
    logic [0:0]  s_axis_tuser = '0;     // [0] button
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] m_axis_tdata;          // [7:0] move_x, [15:8] move_y, [17:16] mode,
                                        // [25:18] red, [33:26] green, [41:34] blue,
                                        // [49:42] white, [55:50] zero
    logic [1:0]  m_axis_tuser;          // [0] move_valid, [1] mode_changed
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;

    t_report pending_reports[$];
    t_move   expected_moves[$];
    int      n_sent = 0;
    int      n_errors = 0;
    int      n_cycles = 0;

    // Predictor state
    logic       sw_last = 1'b0;
    logic [1:0] cur_mode = MODE_SLOW;

    trackball_accel_curve_modes_top #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .MODE_COUNT    (MODE_COUNT)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // num/den in unsigned fixed point, rounded half up
    function automatic longint unsigned coef_fix(longint unsigned num, longint unsigned den);
        return (((2 * num) << COEF_FRAC_BITS) + den) / (2 * den);
    endfunction

    // Cubic curve on the magnitude, truncated, clipped at 127, sign put back
    function automatic logic [7:0] curve_move(logic [7:0] d, logic [1:0] mode);
        longint unsigned c3, c2, c1, m, mag;
        logic            neg;
        if (d == 8'd0)
            return 8'd0;
        neg = d[7];
        m = neg ? (longint'(256) - longint'(d)) : longint'(d);
        case (mode)
            MODE_SLOW: begin
                c3 = coef_fix(3, 10); c2 = coef_fix(4, 10); c1 = coef_fix(3, 10);
            end
            MODE_NORMAL: begin
                c3 = coef_fix(4, 10); c2 = coef_fix(3, 10); c1 = coef_fix(3, 10);
            end
            default: begin
                c3 = coef_fix(1, 2);  c2 = coef_fix(1, 4);  c1 = coef_fix(1, 4);
            end
        endcase
        mag = (c3 * m * m * m + c2 * m * m + c1 * m) >> COEF_FRAC_BITS;
        if (mag > MOVE_LIMIT)
            mag = MOVE_LIMIT;
        return neg ? 8'(longint'(256) - mag) : mag[7:0];
    endfunction

    // Steps the mode on a rising switch edge and works out the move item
    function automatic t_move accel_report(logic [7:0] dx, logic [7:0] dy, logic btn);
        t_move      r;
        logic [1:0] nxt;
        r.changed = 1'b0;
        if (btn && !sw_last) begin
            nxt = cur_mode + 2'd1;
            if (int'(nxt) >= MODE_COUNT)
                nxt = MODE_SLOW;
            cur_mode = nxt;
            r.changed = 1'b1;
        end
        sw_last = btn;
        r.move_x = curve_move(dx, cur_mode);
        r.move_y = curve_move(dy, cur_mode);
        r.valid  = (dx != 8'd0) || (dy != 8'd0);
        r.mode   = cur_mode;
        case (cur_mode)
            MODE_SLOW:   r.led = '{red: 8'h00, green: LED_ON, blue: 8'h00, white: LED_ON};
            MODE_NORMAL: r.led = '{red: 8'h00, green: 8'h00, blue: LED_ON, white: LED_ON};
            default:     r.led = '{red: LED_ON, green: 8'h00, blue: 8'h00, white: LED_ON};
        endcase
        return r;
    endfunction

    function automatic int idle_phase();
        return (n_sent < PHASE_LEN) ? 0 : (n_sent < 2 * PHASE_LEN) ? 1 : 2;
    endfunction

    task automatic add_report(int dx, int dy, logic btn, logic hold_off = 1'b0);
        t_report r;
        r.dx = 8'(dx);
        r.dy = 8'(dy);
        r.btn = btn;
        r.hold_off = hold_off;
        pending_reports.push_back(r);
    endtask

    // Mostly small motion, with random bytes and extreme values mixed in
    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1, 2, 3: return 8'($urandom_range(0, 18) - 9);
            4, 5:    return 8'($urandom_range(0, 80) - 40);
            6, 7:    return 8'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 8'h7f;
                    1:       return 8'h80;
                    2:       return 8'h01;
                    default: return 8'hff;
                endcase
            end
        endcase
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            n_errors++;
        end
    endtask

    // Driver: presents the next report once the current one is taken
    always @(posedge i_clk) begin : drive_reports
        t_report nxt;
        logic    show;
        int      idle_pct;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expected_moves.push_back(accel_report(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                                      s_axis_tuser[0]));
                n_sent++;
            end
            case (idle_phase())
                0:       idle_pct = 21;
                1:       idle_pct = 71;
                default: idle_pct = 0;
            endcase
            show = 1'b0;
            if (pending_reports.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                nxt = pending_reports[0];
                if (!nxt.hold_off || expected_moves.size() == 0) begin
                    void'(pending_reports.pop_front());
                    s_axis_tdata <= {nxt.dy, nxt.dx};
                    s_axis_tuser <= nxt.btn;
                    show = 1'b1;
                end
            end
            s_axis_tvalid <= show;
        end
    end

    // Monitor: checks each move item against the oldest prediction
    always @(posedge i_clk) begin : check_moves
        t_move want;
        int    stall_pct;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_moves.size() == 0) begin
                    $display("%0t: unexpected move item, expected none actual %0h/%0h",
                             $time, m_axis_tdata, m_axis_tuser);
                    n_errors++;
                end else begin
                    want = expected_moves.pop_front();
                    check_field("move_x", want.move_x, m_axis_tdata[7:0]);
                    check_field("move_y", want.move_y, m_axis_tdata[15:8]);
                    check_field("speed_mode", 8'(want.mode), 8'(m_axis_tdata[17:16]));
                    check_field("led_red", want.led.red, m_axis_tdata[25:18]);
                    check_field("led_green", want.led.green, m_axis_tdata[33:26]);
                    check_field("led_blue", want.led.blue, m_axis_tdata[41:34]);
                    check_field("led_white", want.led.white, m_axis_tdata[49:42]);
                    check_field("tdata pad", 8'h00, 8'(m_axis_tdata[55:50]));
                    check_field("move_valid", 8'(want.valid), 8'(m_axis_tuser[0]));
                    check_field("mode_changed", 8'(want.changed), 8'(m_axis_tuser[1]));
                end
            end
            case (idle_phase())
                0:       stall_pct = 71;
                1:       stall_pct = 21;
                default: stall_pct = 0;
            endcase
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL trackball_accel_curve_modes_top");
            $finish;
        end
    end

    initial begin : stimulus
        logic btn_level;
        btn_level = 1'b0;

        // Directed: zero motion, zero axis, extremes, clip edge, mode steps and wrap
        add_report(0, 0, 1'b0);
        add_report(1, 0, 1'b0);
        add_report(0, -1, 1'b0);
        add_report(127, -128, 1'b0);
        add_report(-128, 127, 1'b0);
        add_report(7, -7, 1'b0);
        add_report(8, -6, 1'b0);
        add_report(3, 5, 1'b1);             // edge: slow -> normal
        add_report(7, -7, 1'b1);            // held, no step
        add_report(-128, 0, 1'b1);
        add_report(0, 0, 1'b0);
        add_report(0, 0, 1'b1);             // edge with no motion: normal -> fast
        add_report(6, -6, 1'b0);
        add_report(127, 1, 1'b0);
        add_report(-1, -128, 1'b1);         // edge: fast wraps to slow
        add_report(4, -4, 1'b0);
        add_report(85, -86, 1'b1);          // alternating bit patterns
        add_report(-86, 85, 1'b0);
        add_report(2, 2, 1'b1, 1'b1);       // sent only after the datapath drains
        add_report(-2, -3, 1'b0);

        for (int i = 0; i < RANDOM_REPORTS; i++) begin
            // switch mostly held, with presses and releases now and then
            if ($urandom_range(0, 99) < 30)
                btn_level = ~btn_level;
            add_report(pick_delta(), pick_delta(), btn_level,
                       (i == 500 || i == 1150) ? 1'b1 : 1'b0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reports.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (expected_moves.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("PASS trackball_accel_curve_modes_top");
        end else begin
            $display("FAIL trackball_accel_curve_modes_top");
        end
        $finish;
    end

endmodule
